### src/mp2d_pkg.sv
`timescale 1ns / 1ps
// Shared constants and register codes for the streaming 2-D max pooling block.
package mp2d_pkg;

  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_HEIGHT_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  // Window side register and position inside a window.
  localparam int WS_W      = 4;
  localparam int WIN_POS_W = 3;

  // Frame size registers.
  localparam int DIM_W = 9;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [WS_W-1:0]  WS_RESET = 4'd2;
  localparam logic [WS_W-1:0]  WS_MAX   = 4'd8;
  localparam logic [DIM_W-1:0] FW_RESET = 9'd28;
  localparam logic [DIM_W-1:0] FH_RESET = 9'd28;

  // Lanes of the geometry divider.
  localparam int DIV_LANES = 4;
  localparam int LANE_FW   = 0;
  localparam int LANE_FH   = 1;
  localparam int LANE_COL  = 2;
  localparam int LANE_ROW  = 3;

  // Depth of the result queue in front of the output port.
  localparam int OUT_DEPTH = 4;

endpackage

### src/mp2d_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: several numerators share one small divisor.
module mp2d_div #(
  parameter int NUM_W = 9,
  parameter int LANES = mp2d_pkg::DIV_LANES
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [mp2d_pkg::WS_W-1:0]              divisor,
  input  logic [LANES-1:0][NUM_W-1:0]            numer,
  output logic                                   busy,
  output logic                                   done,
  output logic [LANES-1:0][NUM_W-1:0]            quot,
  output logic [LANES-1:0][mp2d_pkg::WS_W-1:0]   rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic                                 busy_r;
  logic                                 done_r;
  logic [CNT_W-1:0]                     cnt_r;
  logic [mp2d_pkg::WS_W-1:0]            div_r;
  logic [LANES-1:0][NUM_W-1:0]          num_r;
  logic [LANES-1:0][NUM_W-1:0]          num_nxt;
  logic [LANES-1:0][mp2d_pkg::WS_W-1:0] rem_r;
  logic [LANES-1:0][mp2d_pkg::WS_W-1:0] rem_nxt;

  // One quotient bit per lane per cycle; the numerator register fills with the quotient.
  always_comb begin
    logic [mp2d_pkg::WS_W:0] trial;
    logic                    ge;
    for (int l = 0; l < LANES; l++) begin
      trial = {rem_r[l], num_r[l][NUM_W-1]};
      ge    = (trial >= {1'b0, div_r});
      if (ge) begin
        rem_nxt[l] = mp2d_pkg::WS_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt[l] = mp2d_pkg::WS_W'(trial);
      end
      num_nxt[l] = {num_r[l][NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = num_r;
  assign rem  = rem_r;

endmodule

### src/max_pool_2d_stream_core.sv
`timescale 1ns / 1ps
// Top level of the streaming non-overlapping 2-D max pooling block.
// A pooled value is registered through the line store stage and then the result queue after the
// transfer of the bottom-right sample of its window, and only then shows on the output.
// Throughput: one sample per cycle, set by the single read and write port of the line
// store; samples also stall while the four-entry result queue is full or about to fill. After
// reset and after every configuration transfer a bit-serial divider recomputes the window
// geometry; in_stall stays high and cfg_ready low until its results have been taken over.
// Reset is synchronous and active low; the line store is not cleared.
module max_pool_2d_stream_core #(
  parameter int MAX_WIDTH   = mp2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = mp2d_pkg::MAX_HEIGHT_DEF,
  parameter int SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Sample input.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  // Pooled result output.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_pooled_value,
  output logic                                out_last_of_frame,
  // Register writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int WS_W  = mp2d_pkg::WS_W;
  localparam int WP_W  = mp2d_pkg::WIN_POS_W;
  localparam int DIM_W = mp2d_pkg::DIM_W;
  // Column and row counters, and the widths that can also hold the frame limits.
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int FW_W  = CW + 1;
  localparam int FH_W  = RW + 1;
  localparam int FX_W  = (FW_W > DIM_W) ? FW_W : DIM_W;
  localparam int FY_W  = (FH_W > DIM_W) ? FH_W : DIM_W;
  localparam int NW    = ((CW > RW) ? CW : RW) + 1;
  localparam int PTR_W = $clog2(mp2d_pkg::OUT_DEPTH);
  localparam int CNT_W = $clog2(mp2d_pkg::OUT_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers and their clamped working values.
  // ---------------------------------------------------------------------------
  logic [WS_W-1:0]  ws_cfg_r;
  logic [DIM_W-1:0] fw_cfg_r;
  logic [DIM_W-1:0] fh_cfg_r;
  logic [WS_W-1:0]  ws_eff;
  logic [FW_W-1:0]  fw_eff;
  logic [FH_W-1:0]  fh_eff;
  logic [FX_W-1:0]  fw_ext;
  logic [FY_W-1:0]  fh_ext;
  logic             cfg_fire;

  assign cfg_fire = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_cfg_r <= mp2d_pkg::WS_RESET;
      fw_cfg_r <= mp2d_pkg::FW_RESET;
      fh_cfg_r <= mp2d_pkg::FH_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        mp2d_pkg::CFG_WINDOW_SIZE:  ws_cfg_r <= cfg_data[WS_W-1:0];
        mp2d_pkg::CFG_FRAME_WIDTH:  fw_cfg_r <= cfg_data[DIM_W-1:0];
        mp2d_pkg::CFG_FRAME_HEIGHT: fh_cfg_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size behaves as one; anything above the supported maximum behaves as the maximum.
  always_comb begin
    fw_ext = FX_W'(fw_cfg_r);
    fh_ext = FY_W'(fh_cfg_r);

    if (ws_cfg_r == '0) begin
      ws_eff = WS_W'(1);
    end else if (ws_cfg_r > mp2d_pkg::WS_MAX) begin
      ws_eff = mp2d_pkg::WS_MAX;
    end else begin
      ws_eff = ws_cfg_r;
    end

    if (fw_ext == '0) begin
      fw_eff = FW_W'(1);
    end else if (fw_ext > FX_W'(MAX_WIDTH)) begin
      fw_eff = FW_W'(MAX_WIDTH);
    end else begin
      fw_eff = FW_W'(fw_ext);
    end

    if (fh_ext == '0) begin
      fh_eff = FH_W'(1);
    end else if (fh_ext > FY_W'(MAX_HEIGHT)) begin
      fh_eff = FH_W'(MAX_HEIGHT);
    end else begin
      fh_eff = FH_W'(fh_ext);
    end
  end

  // ---------------------------------------------------------------------------
  // Geometry recompute. The divider yields the number of whole windows across
  // and down, and splits the current column and row positions into a pooled
  // index and an offset. Those are then stepped along with the raw counters,
  // so no division is needed per sample.
  // ---------------------------------------------------------------------------
  logic                                 calc_req_r;
  logic                                 div_start;
  logic                                 div_busy;
  logic                                 div_done;
  logic                                 busy;
  logic [mp2d_pkg::DIV_LANES-1:0][NW-1:0]   div_numer;
  logic [mp2d_pkg::DIV_LANES-1:0][NW-1:0]   div_quot;
  logic [mp2d_pkg::DIV_LANES-1:0][WS_W-1:0] div_rem;

  // Position state.
  logic [CW-1:0]   col_r,  col_nxt;
  logic [RW-1:0]   row_r,  row_nxt;
  logic [WP_W-1:0] ciw_r,  ciw_nxt;
  logic [WP_W-1:0] riw_r,  riw_nxt;
  logic [CW-1:0]   pcol_r, pcol_nxt;
  logic [RW-1:0]   prow_r, prow_nxt;
  logic [WP_W-1:0] crem_r, crem_nxt;
  logic [WP_W-1:0] rrem_r, rrem_nxt;
  logic [FW_W-1:0] pooled_w_r, pooled_w_nxt;
  logic [FH_W-1:0] pooled_h_r, pooled_h_nxt;

  assign busy      = calc_req_r || div_busy || div_done;
  assign div_start = calc_req_r && !div_busy && !div_done;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calc_req_r <= 1'b1;
    end else if (cfg_fire) begin
      calc_req_r <= 1'b1;
    end else if (div_start) begin
      calc_req_r <= 1'b0;
    end
  end

  always_comb begin
    div_numer                     = '0;
    div_numer[mp2d_pkg::LANE_FW]  = NW'(fw_eff);
    div_numer[mp2d_pkg::LANE_FH]  = NW'(fh_eff);
    div_numer[mp2d_pkg::LANE_COL] = NW'(col_r);
    div_numer[mp2d_pkg::LANE_ROW] = NW'(row_r);
  end

  mp2d_div #(
    .NUM_W (NW),
    .LANES (mp2d_pkg::DIV_LANES)
  ) u_mp2d_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (ws_eff),
    .numer   (div_numer),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  // ---------------------------------------------------------------------------
  // Sample stage: window bookkeeping, row-segment maximum and line store read.
  // ---------------------------------------------------------------------------
  logic                          accept;
  logic [WP_W-1:0]               ciw_eff;
  logic [WP_W-1:0]               riw_eff;
  logic                          end_col_win;
  logic                          end_row_win;
  logic                          end_row;
  logic                          end_frame;
  logic                          in_region;
  logic                          last_win;
  logic                          crem_wrap;
  logic                          rrem_wrap;
  logic                          s1_go;
  logic signed [SAMPLE_BITS-1:0] seg;
  logic signed [SAMPLE_BITS-1:0] running_max_r;

  // Result queue occupancy, needed here for the stall decision.
  logic [CNT_W-1:0]              count_r;
  logic                          push;
  logic                          pop;

  // Stall while the geometry is recomputed, or when the queue could not take
  // the result of the item that is accepted now.
  assign in_stall = busy || ((count_r + CNT_W'(push)) >= CNT_W'(mp2d_pkg::OUT_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    // A window position left over from a larger window restarts at zero.
    ciw_eff     = (WS_W'(ciw_r) >= ws_eff) ? '0 : ciw_r;
    riw_eff     = (WS_W'(riw_r) >= ws_eff) ? '0 : riw_r;
    end_col_win = (WS_W'(ciw_eff) + WS_W'(1)) >= ws_eff;
    end_row_win = (WS_W'(riw_eff) + WS_W'(1)) >= ws_eff;
    end_row     = ({1'b0, col_r} + FW_W'(1)) >= fw_eff;
    end_frame   = end_row && (({1'b0, row_r} + FH_W'(1)) >= fh_eff);
    // Samples beyond the last whole window in either direction are consumed silently.
    in_region   = ({1'b0, pcol_r} < pooled_w_r) && ({1'b0, prow_r} < pooled_h_r);
    last_win    = (({1'b0, pcol_r} + FW_W'(1)) == pooled_w_r) &&
                  (({1'b0, prow_r} + FH_W'(1)) == pooled_h_r);
    crem_wrap   = (WS_W'(crem_r) + WS_W'(1)) == ws_eff;
    rrem_wrap   = (WS_W'(rrem_r) + WS_W'(1)) == ws_eff;
    s1_go       = accept && in_region && end_col_win;

    if (ciw_eff == '0) begin
      seg = in_sample;
    end else if (running_max_r > in_sample) begin
      seg = running_max_r;
    end else begin
      seg = in_sample;
    end
  end

  // Counter stepping. The divider result takes over after a recompute; no sample
  // can be accepted in that cycle.
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    ciw_nxt      = ciw_r;
    riw_nxt      = riw_r;
    pcol_nxt     = pcol_r;
    prow_nxt     = prow_r;
    crem_nxt     = crem_r;
    rrem_nxt     = rrem_r;
    pooled_w_nxt = pooled_w_r;
    pooled_h_nxt = pooled_h_r;

    if (div_done) begin
      pooled_w_nxt = FW_W'(div_quot[mp2d_pkg::LANE_FW]);
      pooled_h_nxt = FH_W'(div_quot[mp2d_pkg::LANE_FH]);
      pcol_nxt     = CW'(div_quot[mp2d_pkg::LANE_COL]);
      prow_nxt     = RW'(div_quot[mp2d_pkg::LANE_ROW]);
      crem_nxt     = WP_W'(div_rem[mp2d_pkg::LANE_COL]);
      rrem_nxt     = WP_W'(div_rem[mp2d_pkg::LANE_ROW]);
    end else if (accept) begin
      if (end_row) begin
        col_nxt  = '0;
        ciw_nxt  = '0;
        pcol_nxt = '0;
        crem_nxt = '0;
        if (end_frame) begin
          row_nxt  = '0;
          riw_nxt  = '0;
          prow_nxt = '0;
          rrem_nxt = '0;
        end else begin
          row_nxt = row_r + RW'(1);
          riw_nxt = end_row_win ? '0 : riw_eff + WP_W'(1);
          if (rrem_wrap) begin
            rrem_nxt = '0;
            prow_nxt = prow_r + RW'(1);
          end else begin
            rrem_nxt = rrem_r + WP_W'(1);
          end
        end
      end else begin
        col_nxt = col_r + CW'(1);
        ciw_nxt = end_col_win ? '0 : ciw_eff + WP_W'(1);
        // The row position is kept in its restarted form, as every sample sees it.
        riw_nxt = riw_eff;
        if (crem_wrap) begin
          crem_nxt = '0;
          pcol_nxt = pcol_r + CW'(1);
        end else begin
          crem_nxt = crem_r + WP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= '0;
      row_r         <= '0;
      ciw_r         <= '0;
      riw_r         <= '0;
      pcol_r        <= '0;
      prow_r        <= '0;
      crem_r        <= '0;
      rrem_r        <= '0;
      pooled_w_r    <= '0;
      pooled_h_r    <= '0;
      running_max_r <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      ciw_r      <= ciw_nxt;
      riw_r      <= riw_nxt;
      pcol_r     <= pcol_nxt;
      prow_r     <= prow_nxt;
      crem_r     <= crem_nxt;
      rrem_r     <= rrem_nxt;
      pooled_w_r <= pooled_w_nxt;
      pooled_h_r <= pooled_h_nxt;
      if (accept && in_region) begin
        running_max_r <= seg;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store stage. The entry for a pooled column is read when a window row
  // segment closes and written back in the next cycle with the merged maximum.
  // When the same column is read in the cycle it is being written (one pooled
  // column with one-sample windows), the value being written is forwarded.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] line_store [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] mem_rd_r;
  logic                          s1_valid_r;
  logic                          s1_emit_r;
  logic                          s1_first_r;
  logic                          s1_last_r;
  logic signed [SAMPLE_BITS-1:0] s1_seg_r;
  logic [CW-1:0]                 s1_addr_r;
  logic                          fwd_r;
  logic signed [SAMPLE_BITS-1:0] fwd_data_r;
  logic signed [SAMPLE_BITS-1:0] rd_eff;
  logic signed [SAMPLE_BITS-1:0] acc;

  always_comb begin
    rd_eff = fwd_r ? fwd_data_r : mem_rd_r;
    if (s1_first_r) begin
      acc = s1_seg_r;
    end else if (rd_eff > s1_seg_r) begin
      acc = rd_eff;
    end else begin
      acc = s1_seg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1_emit_r  <= end_row_win;
      s1_first_r <= (riw_eff == '0);
      s1_last_r  <= last_win;
      s1_seg_r   <= seg;
      s1_addr_r  <= pcol_r;
      fwd_r      <= s1_valid_r && (s1_addr_r == pcol_r);
      fwd_data_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      line_store[s1_addr_r] <= acc;
    end
    if (s1_go) begin
      mem_rd_r <= line_store[pcol_r];
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue. It decouples the pooling pipeline from the output so that a
  // stalled result does not hold up incoming samples until the queue fills.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] q_val_r  [mp2d_pkg::OUT_DEPTH];
  logic                          q_last_r [mp2d_pkg::OUT_DEPTH];
  logic [PTR_W-1:0]              wr_ptr_r;
  logic [PTR_W-1:0]              rd_ptr_r;

  assign push = s1_valid_r && s1_emit_r;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_val_r[wr_ptr_r]  <= acc;
      q_last_r[wr_ptr_r] <= s1_last_r;
    end
  end

  assign out_valid         = (count_r != '0);
  assign out_pooled_value  = q_val_r[rd_ptr_r];
  assign out_last_of_frame = q_last_r[rd_ptr_r];

endmodule

### src/mp2d_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the max pooling block, bound to its top level.
module mp2d_checker #(
  parameter int SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [SAMPLE_BITS-1:0]          out_pooled_value,
  input logic                            out_last_of_frame,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pooled_value) &&
                               $stable(out_last_of_frame))
    else $error("stalled result changed or was withdrawn");

  // A register transfer starts a geometry recompute that blocks samples and writes.
  a_cfg_recalc: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> in_stall && !cfg_ready)
    else $error("no recompute after a register transfer");

  // Reset also starts a recompute.
  a_reset_recalc: assert property (@(posedge clk)
    !rst_n |=> in_stall && !cfg_ready)
    else $error("block not busy after reset");

  // While registers cannot be written, no sample may be taken either.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_ready |-> in_stall)
    else $error("sample accepted during recompute");

  // A new result only ever appears after a sample transfer, via the line store stage.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a matching sample transfer");

endmodule

bind max_pool_2d_stream_core mp2d_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mp2d_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_pooled_value  (out_pooled_value),
  .out_last_of_frame (out_last_of_frame),
  .cfg_valid         (cfg_valid),
  .cfg_ready         (cfg_ready)
);

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 2-D max pooling block.
module tb;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  // Allows for a sample still in flight through the line store stage and the result queue.
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1050;
  // The fourth register index has no register behind it. Writes to it must be harmless.
  localparam logic [mp2d_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One expected pooled result.
  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
  } pooled_t;

  // Scoreboard: keeps its own copy of the registers, the line store and the counters.
  // It predicts the window maxima from every accepted sample and checks the results in order.
  class pooled_scoreboard;
    logic [mp2d_pkg::WS_W-1:0]  ws_reg;
    logic [mp2d_pkg::DIM_W-1:0] fw_reg;
    logic [mp2d_pkg::DIM_W-1:0] fh_reg;
    logic signed [15:0] column_max [256];
    logic signed [15:0] segment_max;
    int unsigned        col, row, col_in_win, row_in_win;
    pooled_t            expected_maxima [$];
    int                 mismatches;

    function new();
      ws_reg      = mp2d_pkg::WS_RESET;
      fw_reg      = mp2d_pkg::FW_RESET;
      fh_reg      = mp2d_pkg::FH_RESET;
      segment_max = '0;
      col         = 0;
      row         = 0;
      col_in_win  = 0;
      row_in_win  = 0;
      mismatches  = 0;
      foreach (column_max[i]) column_max[i] = '0;
    endfunction

    function void write_reg(logic [mp2d_pkg::CFG_IDX_W-1:0] index,
                            logic [mp2d_pkg::CFG_DATA_W-1:0] data);
      case (index)
        mp2d_pkg::CFG_WINDOW_SIZE:  ws_reg = data[mp2d_pkg::WS_W-1:0];
        mp2d_pkg::CFG_FRAME_WIDTH:  fw_reg = data;
        mp2d_pkg::CFG_FRAME_HEIGHT: fh_reg = data;
        default: ;
      endcase
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // Next sample starts a window row, so every store entry it can read gets written first.
    function bit at_window_row_start();
      return col == 0 && row_in_win == 0;
    endfunction

    function bit at_frame_start();
      return col == 0 && row == 0 && row_in_win == 0;
    endfunction

    function void absorb_sample(logic signed [15:0] v);
      int unsigned        ws, fw, fh, pw, ph, pcol;
      logic signed [15:0] seg, acc;
      bit                 col_win_end, row_win_end, row_end, frame_end;
      pooled_t            item;
      ws = clamp(32'(ws_reg), 8);
      fw = clamp(32'(fw_reg), 256);
      fh = clamp(32'(fh_reg), 256);
      pw = fw / ws;
      ph = fh / ws;
      if (col_in_win >= ws) col_in_win = 0;
      if (row_in_win >= ws) row_in_win = 0;
      col_win_end = col_in_win + 1 >= ws;
      row_win_end = row_in_win + 1 >= ws;
      row_end     = col + 1 >= fw;
      frame_end   = row_end && (row + 1 >= fh);

      // Samples beyond the last whole window are dropped but still move the counters.
      if (col < pw * ws && row < ph * ws) begin
        pcol = (col / ws) % 256;
        seg = (col_in_win == 0 || v > segment_max) ? v : segment_max;
        segment_max = seg;
        if (col_win_end) begin
          acc = (row_in_win == 0 || seg > column_max[pcol]) ? seg : column_max[pcol];
          column_max[pcol] = acc;
          if (row_win_end) begin
            item.value = acc;
            item.last  = (col / ws + 1 == pw) && (row / ws + 1 == ph);
            expected_maxima.push_back(item);
          end
        end
      end

      if (row_end) begin
        col        = 0;
        col_in_win = 0;
        if (frame_end) begin
          row        = 0;
          row_in_win = 0;
        end else begin
          row++;
          row_in_win = row_win_end ? 0 : row_in_win + 1;
        end
      end else begin
        col++;
        col_in_win = col_win_end ? 0 : col_in_win + 1;
      end
    endfunction

    function void check_pooled(logic signed [15:0] value, logic last);
      pooled_t want;
      if (expected_maxima.size() == 0) begin
        $display("%0t: result with none expected, value %0d last %0b", $time, value, last);
        mismatches++;
        return;
      end
      want = expected_maxima.pop_front();
      if (value !== want.value) begin
        $display("%0t: pooled value mismatch, expected %0d, got %0d",
                 $time, want.value, value);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last_of_frame mismatch, expected %0b, got %0b",
                 $time, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic signed [15:0]                 in_sample = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [15:0]                 out_pooled_value;
  logic                               out_last_of_frame;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [mp2d_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [mp2d_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

  pooled_scoreboard sb;
  bit               sender_burst = 1'b0;
  int               idle_cycles = 0;
  int               free_left = 0;
  int               stall_left = 0;
  int               random_sent = 0;

  max_pool_2d_stream_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pooled_value (out_pooled_value),
    .out_last_of_frame(out_last_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // The result side alternates free stretches with stalls. Most of each are short,
  // but now and then a long free run or a long stall appears.
  always @(negedge clk) begin
    if (free_left == 0 && stall_left == 0) begin
      free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90) : $urandom_range(0, 6);
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall <= 1'b1;
      stall_left--;
    end
  end

  // Every result transfer is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_pooled(out_pooled_value, out_last_of_frame);
  end

  // Watchdog: a run that stops moving on every channel for too long has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Gap before the next sample. It is mostly nothing or a few cycles, and now and then a long
  // wait. In burst phases there are no gaps at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] random_sample();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2, 3: return 16'(int'($urandom_range(0, 6)) - 3);
      default: return 16'($urandom());
    endcase
  endfunction

  // Window size data with the effective size drawn from lo..hi. Zero or values above eight
  // sometimes stand in for the clamped ends, and the unused upper data bits are random.
  function automatic logic [mp2d_pkg::CFG_DATA_W-1:0] window_data(int lo, int hi);
    logic [3:0] nib;
    logic [4:0] upper;
    nib   = 4'($urandom_range(lo, hi));
    upper = 5'($urandom_range(0, 31));
    if (nib == 1 && $urandom_range(0, 1)) nib = 0;
    if (nib == 8 && $urandom_range(0, 1)) nib = 4'($urandom_range(9, 15));
    return {upper, nib};
  endfunction

  // Frame dimension data with the effective size drawn from lo..hi.
  function automatic logic [mp2d_pkg::CFG_DATA_W-1:0] dim_data(int lo, int hi);
    int eff;
    eff = $urandom_range(lo, hi);
    if (eff == 1 && $urandom_range(0, 1)) return '0;
    if (eff == 256 && $urandom_range(0, 1)) return 9'($urandom_range(257, 511));
    return 9'(eff);
  endfunction

  // Each task below starts and ends at a falling edge.
  task automatic send_sample(input logic signed [15:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.absorb_sample(value);
    @(negedge clk);
  endtask

  // The sender holds off until every predicted result has arrived. Then it waits out the
  // pipeline, because a sample that produces no result may still be in flight.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_maxima.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes. The caller lowers it after the batch.
  task automatic write_reg(input logic [mp2d_pkg::CFG_IDX_W-1:0] index,
                           input logic [mp2d_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(index, data);
    @(negedge clk);
  endtask

  task automatic apply_geometry(input logic [mp2d_pkg::CFG_DATA_W-1:0] ws_d,
                                input logic [mp2d_pkg::CFG_DATA_W-1:0] fw_d,
                                input logic [mp2d_pkg::CFG_DATA_W-1:0] fh_d);
    if ($urandom_range(0, 5) == 0) write_reg(CFG_UNUSED, 9'($urandom()));
    write_reg(mp2d_pkg::CFG_WINDOW_SIZE, ws_d);
    write_reg(mp2d_pkg::CFG_FRAME_WIDTH, fw_d);
    write_reg(mp2d_pkg::CFG_FRAME_HEIGHT, fh_d);
    cfg_valid <= 1'b0;
  endtask

  // Sends random samples until at least `target` have been sent and the stream sits at a
  // clean boundary. Then it drains, so the next geometry change happens with the block idle.
  task automatic run_random_phase(input int target, input bit to_frame_end);
    int n;
    n = 0;
    do begin
      send_sample(random_sample());
      n++;
    end while (n < target ||
               !(to_frame_end ? sb.at_frame_start() : sb.at_window_row_start()));
    random_sent += n;
    drain_results();
  endtask

  initial begin
    int phase, kind;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The opening phase runs the reset geometry: window 2 over a 28-wide frame. Two full
    // rows give one row of pooled results.
    run_random_phase(30, 1'b0);

    // Directed: a 2x2 window over a 5x2 frame. The fifth column is a partial window, and
    // its large values must not leak into any result. The opening phase stopped at the
    // third row, which lies past the new height, so one row of filler closes that frame.
    apply_geometry(9'd2, 9'd5, 9'd2);
    repeat (5) send_sample(16'sh7FFF);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(16'sd100);
    send_sample(-16'sd5);
    send_sample(16'sh7FFF);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh7FFF);
    drain_results();

    // Window size code 12 acts as 8. That is larger than the 3x2 frame, so nothing comes out.
    apply_geometry(9'h1FC, 9'd3, 9'd2);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    drain_results();

    // Window code 0 acts as 1 and width 0 acts as 1, while height 511 clamps to 256. Every
    // sample is its own window, and the frame is left part-way through.
    apply_geometry(9'h1F0, 9'd0, 9'h1FF);
    send_sample(16'sh8001);
    send_sample(16'sh7FFE);
    send_sample(16'sh0001);
    send_sample(16'shFFFE);
    drain_results();

    // The height shrinks to 3 while the row counter is already past it. The next sample
    // closes the frame, and a fresh frame of three rows follows.
    apply_geometry(9'd1, 9'd1, 9'd3);
    send_sample(16'sd7);
    send_sample(-16'sd7);
    send_sample(16'sd300);
    send_sample(-16'sd300);
    drain_results();

    // Random phases. Each rewrites the geometry at a window-row boundary or a frame boundary.
    // Most frames are small, so whole frames and their last flags come by often. A few
    // phases push the width or the height to its maximum.
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      sender_burst = ($urandom_range(0, 4) == 0);
      if (phase == 1) kind = 1;
      else if (phase == 3) kind = 2;
      else kind = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 2) : 0;
      case (kind)
        1: begin
          apply_geometry(window_data(1, 1), dim_data(256, 256), dim_data(1, 3));
          run_random_phase(10, 1'b0);
        end
        2: begin
          apply_geometry(window_data(1, 8), dim_data(1, 4), dim_data(256, 256));
          run_random_phase($urandom_range(20, 60), 1'b0);
        end
        default: begin
          apply_geometry(($urandom_range(0, 3) == 0) ? window_data(5, 8) : window_data(1, 4),
                         ($urandom_range(0, 7) == 0) ? dim_data(1, 24) : dim_data(1, 12),
                         ($urandom_range(0, 7) == 0) ? dim_data(1, 24) : dim_data(1, 12));
          run_random_phase($urandom_range(10, 60), 1'($urandom_range(0, 1)));
        end
      endcase
      phase++;
    end

    // The last phase has already drained. Now watch a little longer for stray results.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_maxima.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
src/mp2d_pkg.sv
src/mp2d_div.sv
src/max_pool_2d_stream_core.sv
src/mp2d_checker.sv
bench/tb.sv
